// File: rtl/smbs_pkg.sv
// Package for the sorted address map lookup block.
// Holds field widths, mode codes and the structs used by the top level, the probe stages and the testbench.
// No dependencies.
package smbs_pkg;

   // Field widths of the request and response transfers.
   localparam int ADDR_WIDTH = 32;
   localparam int INDEX_WIDTH = 10;
   localparam int COUNT_WIDTH = 11;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // Default table depth handed to the top level.
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   // Request mode codes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // Register numbers, taken from the word address.
   localparam logic REG_ENTRY_COUNT = 1'b0;

   // One request: a table write or a lookup.
   typedef struct packed {
      logic                   mode;
      logic [INDEX_WIDTH-1:0] entry_index;
      logic [ADDR_WIDTH-1:0]  native_addr;
      logic [ADDR_WIDTH-1:0]  host_addr;
   } req_type;

   // One lookup response.
   typedef struct packed {
      logic                   found;
      logic [ADDR_WIDTH-1:0]  host_addr_out;
      logic [INDEX_WIDTH-1:0] match_index;
   } rsp_type;

   // Item state carried from one probe stage to the next.
   typedef struct packed {
      logic                   valid;
      logic                   write;
      logic                   found;
      logic [INDEX_WIDTH-1:0] entry_index;
      logic [ADDR_WIDTH-1:0]  key;
      logic [ADDR_WIDTH-1:0]  host;
      logic [ADDR_WIDTH-1:0]  hit_host;
      logic [INDEX_WIDTH-1:0] hit_index;
   } probe_type;

endpackage

// File: rtl/smbs_csr.sv
// Configuration register file of the sorted address map lookup block.
// Holds the entry count behind an APB-style port. Depends on smbs_pkg.
module smbs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [smbs_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [smbs_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [smbs_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready,
   output logic [smbs_pkg::COUNT_WIDTH-1:0]     entry_count
);

   logic [smbs_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [smbs_pkg::COUNT_WIDTH-1:0] count_in;
   logic                             reg_sel;

   // The word address picks the register; byte offset bits are ignored.
   assign reg_sel = (paddr[smbs_pkg::CSR_ADDR_WIDTH-1] == smbs_pkg::REG_ENTRY_COUNT);

   // A write transfer completes in the access phase.
   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         count_in = pwdata[smbs_pkg::COUNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Reads return the register, zero elsewhere.
   always_comb begin
      prdata = '0;
      if (reg_sel) begin
         prdata = smbs_pkg::CSR_DATA_WIDTH'(count_ff);
      end
   end

   assign pready = 1'b1;
   assign entry_count = count_ff;

endmodule

// File: rtl/smbs_probe_stage.sv
// One binary search step of the sorted address map lookup pipeline.
// Owns a full copy of the table, updated as write items pass through.
// Depends on smbs_pkg.
module smbs_probe_stage #(
   parameter int TABLE_DEPTH = smbs_pkg::TABLE_DEPTH_DEFAULT,
   localparam int IW = $clog2(TABLE_DEPTH),
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  smbs_pkg::probe_type  prev_probe,
   input  logic [CW-1:0]        prev_low,
   input  logic [CW-1:0]        prev_limit,
   input  logic [IW-1:0]        prev_mid,
   output smbs_pkg::probe_type  next_probe,
   output logic [CW-1:0]        next_low,
   output logic [CW-1:0]        next_limit,
   output logic [IW-1:0]        next_mid
);

   localparam int AW = smbs_pkg::ADDR_WIDTH;
   localparam int XW = smbs_pkg::INDEX_WIDTH;

   smbs_pkg::probe_type probe_ff;
   logic [CW-1:0]       low_ff;
   logic [CW-1:0]       limit_ff;
   logic [IW-1:0]       mid_ff;
   logic [2*AW-1:0]     entry_ff;
   logic [2*AW-1:0]     table_mem [TABLE_DEPTH];

   logic                write_en;
   logic [IW-1:0]       write_addr;
   logic                searching;
   logic [AW-1:0]       entry_native;
   logic [AW-1:0]       entry_host;
   logic [CW:0]         mid_sum;

   // Item registers; only the valid bit needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff <= prev_probe;
      end
      low_ff <= prev_low;
      limit_ff <= prev_limit;
      mid_ff <= prev_mid;
   end

   // A write item updates this copy as it enters the stage, so lookups ahead
   // of it still see the old entry and lookups behind it see the new one.
   assign write_en = prev_probe.valid && prev_probe.write &&
                     (int'(prev_probe.entry_index) < TABLE_DEPTH);
   assign write_addr = IW'(prev_probe.entry_index);

   always_ff @(posedge clock) begin
      if (write_en) begin
         table_mem[write_addr] <= {prev_probe.key, prev_probe.host};
      end
      entry_ff <= table_mem[prev_mid];
   end

   assign entry_native = entry_ff[2*AW-1:AW];
   assign entry_host = entry_ff[AW-1:0];

   // Still searching while the range is not empty and nothing has matched.
   assign searching = probe_ff.valid && !probe_ff.write && !probe_ff.found &&
                      (low_ff < limit_ff);

   // Compare the probed entry and narrow the range.
   always_comb begin
      next_probe = probe_ff;
      next_low = low_ff;
      next_limit = limit_ff;
      if (searching) begin
         if (entry_native > probe_ff.key) begin
            next_limit = CW'(mid_ff);
         end else if (entry_native < probe_ff.key) begin
            next_low = CW'(mid_ff) + CW'(1);
         end else begin
            next_probe.found = 1'b1;
            next_probe.hit_host = entry_host;
            next_probe.hit_index = XW'(mid_ff);
         end
      end
   end

   // Middle of the inclusive range [low, limit - 1] for the next step.
   assign mid_sum = {1'b0, next_low} + {1'b0, next_limit} - (CW + 1)'(1);
   assign next_mid = IW'(mid_sum >> 1);

endmodule

// File: rtl/sorted_map_binary_search_top.sv
// Sorted address map lookup: top level with the register port and probe pipeline.
// Depends on smbs_pkg, smbs_csr and smbs_probe_stage.
//
// The block takes one item in every cycle and busy stays low: there is no
// stall anywhere. A lookup's one-cycle rsp_valid strobe comes from the output
// register: the first probe stage captures the item at the edge that accepts
// it, there is one register stage per binary search step, each with its own
// copy of the table, and the last stage feeds that output register. Write
// items give no response; they update each stage's copy as they pass it, so
// every lookup sees the table exactly as it stood when that lookup was
// accepted. Responses cannot be held off and must be taken in the cycle their
// strobe is high. The table must be sorted ascending by native address over
// the first entry_count entries, and entry_count must be written only while
// no lookup is in flight; the block itself does not enforce this.
module sorted_map_binary_search_top #(
   parameter int TABLE_DEPTH = smbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  smbs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output smbs_pkg::rsp_type                    rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [smbs_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [smbs_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [smbs_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int NUM_PROBES = $clog2(TABLE_DEPTH + 1);

   logic [smbs_pkg::COUNT_WIDTH-1:0] entry_count;
   logic [CW-1:0]                    count_eff;
   logic [CW:0]                      first_sum;

   smbs_pkg::probe_type link_probe [NUM_PROBES+1];
   logic [CW-1:0]       link_low   [NUM_PROBES+1];
   logic [CW-1:0]       link_limit [NUM_PROBES+1];
   logic [IW-1:0]       link_mid   [NUM_PROBES+1];

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   smbs_pkg::rsp_type   rsp_data_ff;
   smbs_pkg::rsp_type   rsp_data_in;

   // Register port.
   smbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .entry_count (entry_count)
   );

   // The pipeline never stalls, so an item is taken whenever start is high.
   assign busy = 1'b0;

   // A count above the table depth searches the whole table.
   always_comb begin
      if (int'(entry_count) > TABLE_DEPTH) begin
         count_eff = CW'(TABLE_DEPTH);
      end else begin
         count_eff = CW'(entry_count);
      end
   end

   // Build the item entering the first probe stage.
   always_comb begin
      link_probe[0].valid = start && !busy;
      link_probe[0].write = (req_data.mode == smbs_pkg::MODE_WRITE);
      link_probe[0].found = 1'b0;
      link_probe[0].entry_index = req_data.entry_index;
      link_probe[0].key = req_data.native_addr;
      link_probe[0].host = req_data.host_addr;
      link_probe[0].hit_host = '0;
      link_probe[0].hit_index = '0;
   end

   assign link_low[0] = '0;
   assign link_limit[0] = count_eff;
   assign first_sum = {1'b0, count_eff} - (CW + 1)'(1);
   assign link_mid[0] = IW'(first_sum >> 1);

   // One stage for each search step.
   for (genvar s = 0; s < NUM_PROBES; s++) begin : g_probe
      smbs_probe_stage #(
         .TABLE_DEPTH (TABLE_DEPTH)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .prev_probe (link_probe[s]),
         .prev_low   (link_low[s]),
         .prev_limit (link_limit[s]),
         .prev_mid   (link_mid[s]),
         .next_probe (link_probe[s+1]),
         .next_low   (link_low[s+1]),
         .next_limit (link_limit[s+1]),
         .next_mid   (link_mid[s+1])
      );
   end

   // Output register; a miss keeps the zero hit fields set at entry.
   always_comb begin
      rsp_valid_in = link_probe[NUM_PROBES].valid && !link_probe[NUM_PROBES].write;
      rsp_data_in.found = link_probe[NUM_PROBES].found;
      rsp_data_in.host_addr_out = link_probe[NUM_PROBES].hit_host;
      rsp_data_in.match_index = link_probe[NUM_PROBES].hit_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the sorted address map lookup block.
// It drives table writes, lookups and entry_count settings, predicts lookup responses with its own binary search
// or takes them from the directed rows, and depends only on smbs_pkg and sorted_map_binary_search_top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = smbs_pkg::TABLE_DEPTH_DEFAULT;
   localparam int ADDR_WIDTH = smbs_pkg::ADDR_WIDTH;
   localparam int INDEX_WIDTH = smbs_pkg::INDEX_WIDTH;
   localparam int COUNT_WIDTH = smbs_pkg::COUNT_WIDTH;
   localparam int CSR_DATA_WIDTH = smbs_pkg::CSR_DATA_WIDTH;
   localparam int CSR_ADDR_WIDTH = smbs_pkg::CSR_ADDR_WIDTH;
   localparam logic MODE_WRITE = smbs_pkg::MODE_WRITE;
   localparam logic MODE_LOOKUP = smbs_pkg::MODE_LOOKUP;
   // Number of probe stages in the block, one per binary search step.
   localparam int PIPE_LATENCY = $clog2(TABLE_DEPTH + 1);
   // Longest correct quiet stretch is a settle pause plus a register access;
   // the limit is set well above that.
   localparam int QUIET_LIMIT = 400;
   localparam int ITEM_TARGET = 1850;
   localparam logic [CSR_ADDR_WIDTH-1:0] COUNT_ADDR = {smbs_pkg::REG_ENTRY_COUNT, 2'b00};

   typedef enum logic {ROW_XFER, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      smbs_pkg::req_type      req;
      bit                     typed;
      smbs_pkg::rsp_type      want;
      logic [COUNT_WIDTH-1:0] count;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   smbs_pkg::req_type req_data = '0;
   logic rsp_valid;
   smbs_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   // Predictor state: its own copy of the table and of entry_count.
   logic [ADDR_WIDTH-1:0] map_native [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0] map_host [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] cfg_count = '0;

   smbs_pkg::rsp_type pending_lookups [$];
   dir_row_type dir_rows [$];

   int n_errors = 0;
   int n_sent = 0;
   int n_writes = 0;
   int n_lookups = 0;
   int n_hits = 0;
   int n_settings = 0;
   int quiet_cycles = 0;

   sorted_map_binary_search_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // Prints one line per mismatch and counts it; printing stops after 40 mismatches.
   task automatic report_mismatch(string msg);
      n_errors++;
      if (n_errors <= 40) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   // Number of entries that a lookup searches under the current setting.
   function automatic int active_span();
      return (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
   endfunction

   // Binary search over the active entries, the same probe order as the block.
   function automatic smbs_pkg::rsp_type search_table(logic [ADDR_WIDTH-1:0] key);
      smbs_pkg::rsp_type r;
      int lo;
      int hi;
      int mid;
      r = '0;
      lo = 0;
      hi = active_span() - 1;
      while (lo <= hi) begin
         mid = (lo + hi) >> 1;
         if (map_native[mid] > key) begin
            hi = mid - 1;
         end else if (map_native[mid] < key) begin
            lo = mid + 1;
         end else begin
            r.found = 1'b1;
            r.host_addr_out = map_host[mid];
            r.match_index = INDEX_WIDTH'(mid);
            break;
         end
      end
      return r;
   endfunction

   // Random lookup: mostly keys present in the active part, some near misses,
   // the address extremes and fully random keys.
   function automatic smbs_pkg::req_type make_lookup();
      smbs_pkg::req_type r;
      int span;
      int sel;
      span = active_span();
      sel = $urandom_range(99);
      r.mode = MODE_LOOKUP;
      r.entry_index = INDEX_WIDTH'($urandom);
      r.host_addr = $urandom;
      if (span > 0 && sel < 60) begin
         r.native_addr = map_native[$urandom_range(span - 1, 0)];
      end else if (span > 0 && sel < 75) begin
         r.native_addr = map_native[$urandom_range(span - 1, 0)]
                         + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
      end else if (sel < 85) begin
         r.native_addr = $urandom_range(1) ? '0 : '1;
      end else begin
         r.native_addr = $urandom;
      end
      return r;
   endfunction

   function automatic void add_xfer(logic mode, logic [INDEX_WIDTH-1:0] idx,
                                    logic [ADDR_WIDTH-1:0] nat, logic [ADDR_WIDTH-1:0] host,
                                    bit typed, logic found, logic [ADDR_WIDTH-1:0] hit_host,
                                    logic [INDEX_WIDTH-1:0] hit_idx);
      dir_row_type row;
      row.kind = ROW_XFER;
      row.req = '{mode, idx, nat, host};
      row.typed = typed;
      row.want = '{found, hit_host, hit_idx};
      row.count = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [COUNT_WIDTH-1:0] count);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.req = '0;
      row.typed = 1'b0;
      row.want = '0;
      row.count = count;
      dir_rows.push_back(row);
   endfunction

   // Presents one item and waits for its transfer; start stays high afterwards.
   task automatic send_item(smbs_pkg::req_type r, bit typed, smbs_pkg::rsp_type want);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      n_sent++;
      if (r.mode == MODE_WRITE) begin
         map_native[r.entry_index] = r.native_addr;
         map_host[r.entry_index] = r.host_addr;
         n_writes++;
      end else begin
         pending_lookups.push_back(typed ? want : search_table(r.native_addr));
         n_lookups++;
      end
   endtask

   // Sender idles for a random number of cycles, each with the given odds.
   task automatic idle_gap(int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   // Holds the sender off until every pending lookup has answered.
   task automatic drain_lookups();
      start <= 1'b0;
      do @(posedge clock); while (pending_lookups.size() != 0);
   endtask

   // Idle point for a register change: writes may still be in the pipeline.
   task automatic settle();
      drain_lookups();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_access(bit is_write, logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= COUNT_ADDR;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      if (is_write) begin
         cfg_count = wdata[COUNT_WIDTH-1:0];
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Writes entry_count with random upper bits, then reads it back.
   task automatic set_entry_count(logic [COUNT_WIDTH-1:0] count);
      logic [CSR_DATA_WIDTH-1:0] rd;
      settle();
      csr_access(1'b1, {$urandom} & ~CSR_DATA_WIDTH'(11'h7FF) | CSR_DATA_WIDTH'(count), rd);
      csr_access(1'b0, '0, rd);
      n_settings++;
      if (rd !== CSR_DATA_WIDTH'(cfg_count)) begin
         report_mismatch($sformatf("entry_count read %h, expected %h", rd, cfg_count));
      end
   endtask

   // Response checker: each strobe is matched with the oldest pending lookup.
   always @(posedge clock) begin
      smbs_pkg::rsp_type want;
      if (reset == 1'b0 && rsp_valid === 1'b1) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("response with no lookup pending");
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.found === 1'b1) begin
               n_hits++;
            end
            if (rsp_data.found !== want.found) begin
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_data.found, want.found));
            end
            if (rsp_data.host_addr_out !== want.host_addr_out) begin
               report_mismatch($sformatf("host_addr_out %h, expected %h",
                                         rsp_data.host_addr_out, want.host_addr_out));
            end
            if (rsp_data.match_index !== want.match_index) begin
               report_mismatch($sformatf("match_index %0d, expected %0d",
                                         rsp_data.match_index, want.match_index));
            end
         end
      end
   end

   // Watchdog: any transfer on any port restarts the quiet count.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1
          || (psel === 1'b1 && penable === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed table, full sorted fill, then random phases.
   initial begin
      int idle_pcts [4];
      int forced_counts [7];
      logic [32:0] acc;
      logic [ADDR_WIDTH-1:0] lo_b;
      logic [ADDR_WIDTH-1:0] hi_b;
      logic [COUNT_WIDTH-1:0] count;
      smbs_pkg::req_type r;
      int base;
      int phase;
      int len;
      int drain_at;
      int idx;
      int sel;

      idle_pcts = '{0, 53, 0, 24};
      forced_counts = '{1024, 2047, 1025, 0, 1, 2, 3};

      // Empty table after reset, then a small sorted table with both extremes.
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0000, 32'h0, 1, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_LOOKUP, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_WRITE, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_WRITE, 10'd1, 32'h0000_0005, 32'h0000_0001, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_WRITE, 10'd2, 32'h8000_0000, 32'h1234_5678, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_WRITE, 10'd3, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_WRITE, 10'h3FF, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 0, 1'b0, 32'h0, 10'd0);
      add_csr(11'd4);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0000, 32'h0, 1, 1'b1, 32'hFFFF_FFFF, 10'd0);
      add_xfer(MODE_LOOKUP, 10'd0, 32'hFFFF_FFFF, 32'h0, 1, 1'b1, 32'h0000_0000, 10'd3);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0005, 32'h0, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0006, 32'h0, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_LOOKUP, 10'h3FF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1'b0, 32'h0, 10'd0);
      // Single entry table.
      add_csr(11'd1);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0000, 32'h0, 1, 1'b1, 32'hFFFF_FFFF, 10'd0);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0005, 32'h0, 1, 1'b0, 32'h0, 10'd0);
      // A zero count misses even though entries are stored.
      add_csr(11'd0);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0000, 32'h0, 1, 1'b0, 32'h0, 10'd0);
      // Unsorted entry makes the search pass by a key that is present.
      add_csr(11'd4);
      add_xfer(MODE_WRITE, 10'd0, 32'h9000_0000, 32'h0000_0007, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h9000_0000, 32'h0, 0, 1'b0, 32'h0, 10'd0);
      // Lookup right behind the write that it depends on.
      add_xfer(MODE_WRITE, 10'd1, 32'h0000_0006, 32'h0000_0002, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0006, 32'h0, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_WRITE, 10'd0, 32'h0000_0000, 32'h0000_0003, 0, 1'b0, 32'h0, 10'd0);
      add_xfer(MODE_LOOKUP, 10'd0, 32'h0000_0007, 32'h0, 0, 1'b0, 32'h0, 10'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            set_entry_count(dir_rows[i].count);
         end else begin
            send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Fill the whole table in sorted order, with duplicates, lookups mixed in.
      base = n_sent;
      acc = $urandom_range(1) ? 33'd0 : 33'($urandom_range(1000));
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i == TABLE_DEPTH / 2) begin
            drain_lookups();
         end else begin
            idle_gap(24);
         end
         if ($urandom_range(3) == 0) begin
            send_item(make_lookup(), 1'b0, '0);
            idle_gap(24);
         end
         r.mode = MODE_WRITE;
         r.entry_index = INDEX_WIDTH'(i);
         r.native_addr = (i == TABLE_DEPTH - 1 || acc[32]) ? '1 : acc[31:0];
         r.host_addr = $urandom;
         send_item(r, 1'b0, '0);
         acc = acc + (($urandom_range(9) == 0) ? 33'd0 : 33'($urandom_range(8000000, 1)));
      end

      // Random phases, each under its own entry_count and idling pattern.
      phase = 0;
      while (n_sent - base < ITEM_TARGET) begin
         if (phase < 7) begin
            count = COUNT_WIDTH'(forced_counts[phase]);
         end else begin
            sel = $urandom_range(99);
            if (sel < 5) count = '0;
            else if (sel < 15) count = COUNT_WIDTH'($urandom_range(3, 1));
            else if (sel < 65) count = COUNT_WIDTH'($urandom_range(64, 4));
            else if (sel < 90) count = COUNT_WIDTH'($urandom_range(1023, 65));
            else count = COUNT_WIDTH'($urandom_range(2047, 1024));
         end
         set_entry_count(count);
         len = $urandom_range(80, 40);
         drain_at = $urandom_range(len - 5, 5);
         for (int k = 0; k < len; k++) begin
            if (k == drain_at) begin
               drain_lookups();
            end else begin
               idle_gap(idle_pcts[phase % 4]);
            end
            if ($urandom_range(99) < 80) begin
               send_item(make_lookup(), 1'b0, '0);
            end else begin
               // Rewrite one entry, usually keeping the table in order.
               idx = $urandom_range(TABLE_DEPTH - 1);
               lo_b = (idx > 0) ? map_native[idx - 1] : '0;
               hi_b = (idx < TABLE_DEPTH - 1) ? map_native[idx + 1] : '1;
               sel = $urandom_range(9);
               r.mode = MODE_WRITE;
               r.entry_index = INDEX_WIDTH'(idx);
               r.host_addr = $urandom;
               if (sel == 0) r.native_addr = $urandom;
               else if (sel == 1) r.native_addr = lo_b;
               else if (sel == 2) r.native_addr = hi_b;
               else r.native_addr = $urandom_range(hi_b, lo_b);
               send_item(r, 1'b0, '0);
            end
         end
         phase++;
      end

      settle();
      $display("Run covered %0d table writes and %0d lookups (%0d hits) under %0d",
               n_writes, n_lookups, n_hits, n_settings);
      $display("entry_count settings, from an empty table up past the table depth.");
      if (n_errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
